// ===== hdl/mlf_pkg.sv =====
// Shared constants, codes and the character encoder of the Morse line flasher.
package mlf_pkg;

  localparam int unsigned TICK_W    = 16;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned CODE_W    = 8;
  localparam int unsigned SYM_W     = 3;
  localparam int unsigned CFG_IDX_W = 2;

  // item kind carried on tuser
  localparam logic MODE_CHAR = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DOT_TICKS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DASH_TICKS = 2'd1;

  localparam logic [TICK_W-1:0] DOT_TICKS_RST  = 16'd1;
  localparam logic [TICK_W-1:0] DASH_TICKS_RST = 16'd3;

  localparam logic [CHAR_W-1:0] CH_LF = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR = 8'd13;

  // Packed code: length in [7:5], pattern in [4:0], bit i set = symbol i is a dash.
  // Returns zero for anything that is not a letter or a digit.
  function automatic logic [CODE_W-1:0] encode_char(input logic [CHAR_W-1:0] ch);
    logic [CHAR_W-1:0] lc;
    logic [2:0]        len;
    logic [4:0]        pat;
    lc  = ch;
    len = 3'd0;
    pat = 5'd0;
    if (ch >= "A" && ch <= "Z") begin
      lc = ch + 8'd32;
    end
    case (lc)
      "a": begin len = 3'd2; pat = 5'd2;  end
      "b": begin len = 3'd4; pat = 5'd1;  end
      "c": begin len = 3'd4; pat = 5'd5;  end
      "d": begin len = 3'd3; pat = 5'd1;  end
      "e": begin len = 3'd1; pat = 5'd0;  end
      "f": begin len = 3'd4; pat = 5'd4;  end
      "g": begin len = 3'd3; pat = 5'd3;  end
      "h": begin len = 3'd4; pat = 5'd0;  end
      "i": begin len = 3'd2; pat = 5'd0;  end
      "j": begin len = 3'd4; pat = 5'd14; end
      "k": begin len = 3'd3; pat = 5'd5;  end
      "l": begin len = 3'd4; pat = 5'd2;  end
      "m": begin len = 3'd2; pat = 5'd3;  end
      "n": begin len = 3'd2; pat = 5'd1;  end
      "o": begin len = 3'd3; pat = 5'd7;  end
      "p": begin len = 3'd4; pat = 5'd6;  end
      "q": begin len = 3'd4; pat = 5'd11; end
      "r": begin len = 3'd3; pat = 5'd2;  end
      "s": begin len = 3'd3; pat = 5'd0;  end
      "t": begin len = 3'd1; pat = 5'd1;  end
      "u": begin len = 3'd3; pat = 5'd4;  end
      "v": begin len = 3'd4; pat = 5'd8;  end
      "w": begin len = 3'd3; pat = 5'd6;  end
      "x": begin len = 3'd4; pat = 5'd9;  end
      "y": begin len = 3'd4; pat = 5'd13; end
      "z": begin len = 3'd4; pat = 5'd3;  end
      "0": begin len = 3'd5; pat = 5'd31; end
      "1": begin len = 3'd5; pat = 5'd30; end
      "2": begin len = 3'd5; pat = 5'd28; end
      "3": begin len = 3'd5; pat = 5'd24; end
      "4": begin len = 3'd5; pat = 5'd16; end
      "5": begin len = 3'd5; pat = 5'd0;  end
      "6": begin len = 3'd5; pat = 5'd1;  end
      "7": begin len = 3'd5; pat = 5'd3;  end
      "8": begin len = 3'd5; pat = 5'd7;  end
      "9": begin len = 3'd5; pat = 5'd15; end
      default: begin len = 3'd0; pat = 5'd0; end
    endcase
    return {len, pat};
  endfunction

endpackage

// ===== hdl/mlf_line_store.sv =====
// Line buffer of packed Morse codes: one write port, one registered read port.
module mlf_line_store #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [mlf_pkg::CODE_W-1:0] wr_data,
  input  logic [AW-1:0]              rd_addr,
  output logic [mlf_pkg::CODE_W-1:0] rd_data
);

  logic [mlf_pkg::CODE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/morse_line_flasher.sv =====
// Top level of the Morse line flasher: line buffering, tick timing and result register.
//
// Character items (tuser = 0) are stored as Morse codes while the block is idle;
// letters of either case and digits are kept, other bytes are skipped, and a
// newline or carriage return starts flashing the stored line. Tick items
// (tuser = 1) time the LED: a dot is on for dot_ticks and off for dot_ticks,
// a dash likewise with dash_ticks (a zero register acts as one). Every item
// gives exactly one result, registered, in the cycle after acceptance. One item
// is accepted per cycle; the only thing that holds the input back is a result
// that the output side has not taken, and even then the input is open in the
// cycle the output register drains. The line buffer's registered read port
// always prefetches the code after the one being flashed, which is ready well
// before the earliest possible advance (a character lasts at least two ticks).
// The buffer needs no clearing pass: only entries below the stored line length
// are ever played. Characters arriving while flashing, or letters and digits
// arriving with a full buffer, are dropped and flagged.
module morse_line_flasher #(
  parameter int unsigned LINE_DEPTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  // input items
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // [7:0] char_code
  input  logic [0:0]                    s_tuser,   // [0] mode
  // result items
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [7:0]                    m_tdata,   // [0] led, [1] busy_res, [2] dropped,
                                                   // [3] line_done, [7:4] zero
  // configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mlf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mlf_pkg::TICK_W-1:0]    cfg_data
);

  localparam int unsigned AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int unsigned LW = $clog2(LINE_DEPTH + 1);
  localparam logic [LW-1:0] DEPTH_L = LW'(LINE_DEPTH);

  // configuration
  logic [mlf_pkg::TICK_W-1:0] dot_ticks;
  logic [mlf_pkg::TICK_W-1:0] dash_ticks;

  // playback state
  logic [LW-1:0]               line_length, line_length_next;
  logic [LW-1:0]               play_position, play_position_next;
  logic [mlf_pkg::SYM_W-1:0]   symbol_position, symbol_position_next;
  logic                        light_phase, light_phase_next;
  logic [mlf_pkg::TICK_W-1:0]  tick_count, tick_count_next;
  logic                        playing, playing_next;
  logic [mlf_pkg::CODE_W-1:0]  cur_code, cur_code_next;
  logic [mlf_pkg::CODE_W-1:0]  first_code, first_code_next;

  // result register
  logic [3:0] result;
  logic       dropped_next;
  logic       done_next;

  // store ports
  logic                        wr_en;
  logic [mlf_pkg::CODE_W-1:0]  enc_code;
  logic [LW-1:0]               rd_idx;
  logic [AW-1:0]               rd_addr;
  logic [mlf_pkg::CODE_W-1:0]  rd_data;

  logic                        in_accept;
  logic [mlf_pkg::TICK_W-1:0]  dur;
  logic [mlf_pkg::TICK_W-1:0]  dur_eff;
  logic [mlf_pkg::TICK_W:0]    cnt_inc;
  logic [mlf_pkg::SYM_W-1:0]   sym_inc;
  logic [LW-1:0]               pos_inc;

  assign s_tready  = !m_tvalid || m_tready;
  assign in_accept = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  assign enc_code = mlf_pkg::encode_char(s_tdata);

  // prefetch the code after the current one
  assign pos_inc = play_position + LW'(1);
  assign rd_idx  = pos_inc;
  assign rd_addr = (rd_idx < DEPTH_L) ? rd_idx[AW-1:0] : '0;

  mlf_line_store #(
    .DEPTH (LINE_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (line_length[AW-1:0]),
    .wr_data (enc_code),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign dur     = cur_code[symbol_position] ? dash_ticks : dot_ticks;
  assign dur_eff = (dur == '0) ? mlf_pkg::TICK_W'(1) : dur;
  assign cnt_inc = {1'b0, tick_count} + (mlf_pkg::TICK_W + 1)'(1);
  assign sym_inc = symbol_position + mlf_pkg::SYM_W'(1);

  always_comb begin
    line_length_next     = line_length;
    play_position_next   = play_position;
    symbol_position_next = symbol_position;
    light_phase_next     = light_phase;
    tick_count_next      = tick_count;
    playing_next         = playing;
    cur_code_next        = cur_code;
    first_code_next      = first_code;
    dropped_next         = 1'b0;
    done_next            = 1'b0;
    wr_en                = 1'b0;
    if (in_accept) begin
      if (s_tuser[0] == mlf_pkg::MODE_CHAR) begin
        if (playing) begin
          dropped_next = 1'b1;
        end else if (s_tdata == mlf_pkg::CH_LF || s_tdata == mlf_pkg::CH_CR) begin
          if (line_length != '0) begin
            playing_next         = 1'b1;
            play_position_next   = '0;
            symbol_position_next = '0;
            light_phase_next     = 1'b0;
            tick_count_next      = '0;
            cur_code_next        = first_code;
          end
        end else if (enc_code != '0) begin
          if (line_length < DEPTH_L) begin
            wr_en            = 1'b1;
            line_length_next = line_length + LW'(1);
            if (line_length == '0) begin
              first_code_next = enc_code;
            end
          end else begin
            dropped_next = 1'b1;
          end
        end
      end else if (playing) begin
        if (cnt_inc < {1'b0, dur_eff}) begin
          tick_count_next = cnt_inc[mlf_pkg::TICK_W-1:0];
        end else begin
          tick_count_next = '0;
          if (!light_phase) begin
            light_phase_next = 1'b1;
          end else begin
            light_phase_next = 1'b0;
            if (sym_inc < cur_code[7:5]) begin
              symbol_position_next = sym_inc;
            end else begin
              // character finished: move to the prefetched code
              symbol_position_next = '0;
              play_position_next   = pos_inc;
              cur_code_next        = rd_data;
              if (pos_inc >= line_length) begin
                playing_next       = 1'b0;
                play_position_next = '0;
                line_length_next   = '0;
                done_next          = 1'b1;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_ticks       <= mlf_pkg::DOT_TICKS_RST;
      dash_ticks      <= mlf_pkg::DASH_TICKS_RST;
      line_length     <= '0;
      play_position   <= '0;
      symbol_position <= '0;
      light_phase     <= 1'b0;
      tick_count      <= '0;
      playing         <= 1'b0;
      m_tvalid        <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          mlf_pkg::CFG_DOT_TICKS:  dot_ticks  <= cfg_data;
          mlf_pkg::CFG_DASH_TICKS: dash_ticks <= cfg_data;
          default: ;
        endcase
      end
      line_length     <= line_length_next;
      play_position   <= play_position_next;
      symbol_position <= symbol_position_next;
      light_phase     <= light_phase_next;
      tick_count      <= tick_count_next;
      playing         <= playing_next;
      if (in_accept) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    cur_code   <= cur_code_next;
    first_code <= first_code_next;
    if (in_accept) begin
      result <= {done_next, dropped_next, playing_next, playing_next && !light_phase_next};
    end
  end

  assign m_tdata = {4'b0000, result};

  // idle means timing counters are parked at zero
  a_idle_parked: assert property (@(posedge clk) disable iff (rst)
    !playing |-> (tick_count == '0 && !light_phase && symbol_position == '0 &&
                  play_position == '0))
    else $error("timing state not parked while idle");

  // the playing character always lies inside the stored line
  a_pos_in_line: assert property (@(posedge clk) disable iff (rst)
    playing |-> (play_position < line_length && symbol_position < cur_code[7:5]))
    else $error("play position outside the stored line");

  // a finished line is reported as no longer busy
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[3]) |-> (!m_tdata[1] && !m_tdata[0]))
    else $error("line_done reported while still busy");

  // a line end always takes the block back to idle at the same edge
  a_done_idles: assert property (@(posedge clk) disable iff (rst)
    (in_accept && done_next) |=> (!playing && line_length == '0))
    else $error("line end did not return to idle");

endmodule
